### hdl/tbws_pkg.sv
// Shared types and constants for the tracked bit set with scan.
// Holds field widths, request codes, controller states and the command/status structs.
// No dependencies.
package tbws_pkg;

    // Default sizes of the set and of one stored word
    localparam int SET_BITS_DEF  = 1024;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths
    localparam int REQ_W = 3;
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int SUM_W = 19;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SET   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TEST  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NEXT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PREV  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } t_state;

    // What a finished scan updates
    typedef enum logic [1:0] {
        TGT_FIND,
        TGT_LOW,
        TGT_HIGH
    } t_tgt;

    typedef struct packed {
        logic load;        // take a new item, read its word
        logic exec;        // word of the item is on the read port
        logic do_set;      // write the bit and grow count/sum
        logic do_clr;      // clear the bit and shrink count/sum
        logic scan_start;  // set up a word walk
        logic scan_up;     // walk direction
        t_tgt scan_tgt;
        logic scan_step;   // issue next word, check previous
        logic scan_finish; // commit the scan result
        logic out_load;    // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic             was;
        logic             valid_idx;
        logic [REQ_W-1:0] req;
        logic             cnt_one;
        logic             is_low;
        logic             is_high;
        logic             scan_hit;
        logic             scan_end;
        logic             out_free;
    } t_sts;

endpackage

### hdl/tbws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/tbws_ctrl.sv
// Controller for the tracked bit set: sequences load, update, word walk and result.
// Depends on tbws_pkg.
module tbws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tbws_pkg::t_sts i_sts,
    output tbws_pkg::t_cmd o_cmd
);

    tbws_pkg::t_state r_state, n_state;

    logic set_act, clr_act, is_next, is_prev;

    assign set_act = (i_sts.req == tbws_pkg::REQ_SET) && i_sts.valid_idx && !i_sts.was;
    assign clr_act = (i_sts.req == tbws_pkg::REQ_CLEAR) && i_sts.valid_idx && i_sts.was;
    assign is_next = (i_sts.req == tbws_pkg::REQ_NEXT);
    assign is_prev = (i_sts.req == tbws_pkg::REQ_PREV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbws_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbws_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = tbws_pkg::ST_EXEC;
                end
            end
            tbws_pkg::ST_EXEC: begin
                n_state = tbws_pkg::ST_DONE;
                if (set_act) begin
                    n_state = tbws_pkg::ST_DONE;
                end else if (clr_act) begin
                    if (!i_sts.cnt_one && (i_sts.is_low || i_sts.is_high)) begin
                        n_state = tbws_pkg::ST_SCAN;
                    end
                end else if ((is_next && i_sts.valid_idx) || is_prev) begin
                    n_state = tbws_pkg::ST_SCAN;
                end
            end
            tbws_pkg::ST_SCAN: begin
                if (i_sts.scan_hit || i_sts.scan_end) begin
                    n_state = tbws_pkg::ST_DONE;
                end
            end
            tbws_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = tbws_pkg::ST_IDLE;
                end
            end
            default: n_state = tbws_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd    = '0;
        o_cmd.scan_tgt = tbws_pkg::TGT_FIND;
        o_ready  = 1'b0;
        case (r_state)
            tbws_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            tbws_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (set_act) begin
                    o_cmd.do_set = 1'b1;
                end else if (clr_act) begin
                    o_cmd.do_clr = 1'b1;
                    if (!i_sts.cnt_one && i_sts.is_low) begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_up    = 1'b1;
                        o_cmd.scan_tgt   = tbws_pkg::TGT_LOW;
                    end else if (!i_sts.cnt_one && i_sts.is_high) begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_up    = 1'b0;
                        o_cmd.scan_tgt   = tbws_pkg::TGT_HIGH;
                    end
                end else if (is_next && i_sts.valid_idx) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_up    = 1'b1;
                end else if (is_prev) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_up    = 1'b0;
                end
            end
            tbws_pkg::ST_SCAN: begin
                o_cmd.scan_step   = 1'b1;
                o_cmd.scan_finish = i_sts.scan_hit || i_sts.scan_end;
            end
            tbws_pkg::ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### hdl/tbws_dp.sv
// Datapath for the tracked bit set: word store, per-word valid bits, trackers,
// word walk with priority pick, and the output register.
// Depends on tbws_pkg and tbws_ram.
module tbws_dp #(
    parameter int SET_BITS  = tbws_pkg::SET_BITS_DEF,
    parameter int WORD_BITS = tbws_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tbws_pkg::t_cmd             i_cmd,
    output tbws_pkg::t_sts             o_sts,
    input  logic [tbws_pkg::REQ_W-1:0] i_req_type,
    input  logic [tbws_pkg::IDX_W-1:0] i_index,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_bit_value,
    output logic                       o_found,
    output logic [tbws_pkg::IDX_W-1:0] o_found_index,
    output logic [tbws_pkg::IDX_W-1:0] o_lowest_member,
    output logic [tbws_pkg::IDX_W-1:0] o_highest_member,
    output logic [tbws_pkg::CNT_W-1:0] o_member_count,
    output logic [tbws_pkg::SUM_W-1:0] o_member_sum,
    output logic                       o_set_empty
);

    localparam int IDX_W  = tbws_pkg::IDX_W;
    localparam int CNT_W  = tbws_pkg::CNT_W;
    localparam int SUM_W  = tbws_pkg::SUM_W;
    localparam int REQ_W  = tbws_pkg::REQ_W;
    localparam int WORDS  = (SET_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W  = $clog2(WORD_BITS);

    // Item registers
    logic [REQ_W-1:0]  r_req;
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_word;
    logic [BIT_W-1:0]  r_bit;
    logic              r_was;

    // Tracked state
    logic [WORDS-1:0]  r_wvld;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_low, r_high;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_sum;

    // Word walk
    logic              r_dir_up;
    tbws_pkg::t_tgt    r_tgt;
    logic [ADDR_W-1:0] r_scan_addr, r_chk_addr, r_sword;
    logic [BIT_W-1:0]  r_sbit;
    logic              r_chk_vld;
    logic              r_found;
    logic [IDX_W-1:0]  r_hit;

    // Output register
    logic r_out_vld;

    // Combinational
    logic [ADDR_W-1:0]    ram_raddr, end_word;
    logic [WORD_BITS-1:0] ram_q, rd_word, bit_mask, new_word, first_mask, masked;
    logic                 valid_idx, was;
    logic [IDX_W-1:0]     start_pos;
    logic [BIT_W-1:0]     sel;
    logic [IDX_W-1:0]     hit_pos;

    assign valid_idx = 32'(r_idx) < SET_BITS;
    assign rd_word   = r_rd_vld ? ram_q : '0;
    assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit;
    assign was       = valid_idx && ((rd_word & bit_mask) != '0);
    assign new_word  = i_cmd.do_set ? (rd_word | bit_mask) : (rd_word & ~bit_mask);

    assign ram_raddr = i_cmd.load ? ADDR_W'(i_index / WORD_BITS) : r_scan_addr;

    tbws_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(WORDS),
        .AW   (ADDR_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.do_set || i_cmd.do_clr),
        .i_waddr(r_word),
        .i_wdata(new_word),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    // Start of a walk: a backward walk starts no higher than the top member slot
    always_comb begin
        start_pos = r_idx;
        if (!i_cmd.scan_up && !valid_idx) begin
            start_pos = IDX_W'(SET_BITS - 1);
        end
    end

    assign end_word   = r_dir_up ? ADDR_W'(WORDS - 1) : '0;
    assign first_mask = r_dir_up ? ({WORD_BITS{1'b1}} << r_sbit)
                                 : ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - r_sbit));
    assign masked     = rd_word & ((r_chk_addr == r_sword) ? first_mask : {WORD_BITS{1'b1}});

    // Pick lowest set bit walking up, highest walking down
    always_comb begin
        sel = '0;
        if (r_dir_up) begin
            for (int i = WORD_BITS - 1; i >= 0; i--) begin
                if (masked[i]) begin
                    sel = BIT_W'(i);
                end
            end
        end else begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (masked[i]) begin
                    sel = BIT_W'(i);
                end
            end
        end
    end

    assign hit_pos = IDX_W'(32'(r_chk_addr) * WORD_BITS + 32'(sel));

    always_comb begin
        o_sts           = '0;
        o_sts.was       = was;
        o_sts.valid_idx = valid_idx;
        o_sts.req       = r_req;
        o_sts.cnt_one   = (r_cnt == CNT_W'(1));
        o_sts.is_low    = (r_idx == r_low);
        o_sts.is_high   = (r_idx == r_high);
        o_sts.scan_hit  = r_chk_vld && (masked != '0);
        o_sts.scan_end  = r_chk_vld && (r_chk_addr == end_word);
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_idx  <= i_index;
            r_word <= ADDR_W'(i_index / WORD_BITS);
            r_bit  <= BIT_W'(i_index % WORD_BITS);
        end
        if (i_cmd.exec) begin
            r_was <= was;
        end
        r_rd_vld <= (32'(ram_raddr) < WORDS) && r_wvld[ram_raddr];
        if (i_cmd.scan_start) begin
            r_dir_up    <= i_cmd.scan_up;
            r_tgt       <= i_cmd.scan_tgt;
            r_scan_addr <= ADDR_W'(start_pos / WORD_BITS);
            r_sword     <= ADDR_W'(start_pos / WORD_BITS);
            r_sbit      <= BIT_W'(start_pos % WORD_BITS);
        end else if (i_cmd.scan_step) begin
            r_chk_addr <= r_scan_addr;
            if (r_scan_addr != end_word) begin
                r_scan_addr <= r_dir_up ? r_scan_addr + ADDR_W'(1) : r_scan_addr - ADDR_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            o_bit_value      <= r_was;
            o_found          <= r_found;
            o_found_index    <= r_hit;
            o_lowest_member  <= (r_cnt != '0) ? r_low : '0;
            o_highest_member <= (r_cnt != '0) ? r_high : '0;
            o_member_count   <= r_cnt;
            o_member_sum     <= r_sum;
            o_set_empty      <= (r_cnt == '0);
        end
    end

    // Control and tracked state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld    <= '0;
            r_low     <= '0;
            r_high    <= '0;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_chk_vld <= 1'b0;
            r_found   <= 1'b0;
            r_hit     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_found <= 1'b0;
                r_hit   <= '0;
            end
            if (i_cmd.do_set || i_cmd.do_clr) begin
                r_wvld[r_word] <= 1'b1;
            end
            if (i_cmd.do_set) begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_sum <= r_sum + SUM_W'(r_idx);
                if (r_cnt == '0) begin
                    r_low  <= r_idx;
                    r_high <= r_idx;
                end else begin
                    if (r_idx < r_low) begin
                        r_low <= r_idx;
                    end
                    if (r_idx > r_high) begin
                        r_high <= r_idx;
                    end
                end
            end
            if (i_cmd.do_clr) begin
                r_cnt <= r_cnt - CNT_W'(1);
                r_sum <= r_sum - SUM_W'(r_idx);
                if (r_cnt == CNT_W'(1)) begin
                    r_low  <= '0;
                    r_high <= '0;
                end
            end
            if (i_cmd.scan_start) begin
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk_vld <= 1'b1;
            end
            if (i_cmd.scan_finish && o_sts.scan_hit) begin
                case (r_tgt)
                    tbws_pkg::TGT_FIND: begin
                        r_found <= 1'b1;
                        r_hit   <= hit_pos;
                    end
                    tbws_pkg::TGT_LOW:  r_low  <= hit_pos;
                    tbws_pkg::TGT_HIGH: r_high <= hit_pos;
                    default:            r_found <= r_found;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

### hdl/tracked_bitset_with_scan_core.sv
// Top level of the tracked bit set with forward and backward scan.
// Ties the controller (tbws_ctrl) to the datapath (tbws_dp); depends on tbws_pkg.
//
// The block holds a set of integers 0..SET_BITS-1 in a RAM of WORD_BITS-wide words
// and tracks the lowest member, highest member, member count and member sum. Each
// item sets, clears, tests, finds the next member at or after an index, or finds the
// previous member at or before it, and gives exactly one result carrying the prior
// bit, the search outcome and the tracked figures after the item. One item is in
// work at a time. Set, clear and test accept and read the word, update, then load the
// output register once it is free. Searches, and a clear that removes the lowest or
// highest member while other members remain, walk the store one word per cycle
// through the single RAM read port, at most ceil(SET_BITS/WORD_BITS) words, before
// that load. The next item is taken while a result still waits in the output
// register. Reset clears per-word valid bits, so the store needs no clearing pass
// and the block takes items right after reset.
module tracked_bitset_with_scan_core #(
    parameter int SET_BITS  = tbws_pkg::SET_BITS_DEF,
    parameter int WORD_BITS = tbws_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [tbws_pkg::REQ_W-1:0] i_req_type,
    input  logic [tbws_pkg::IDX_W-1:0] i_index,
    // Result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_bit_value,
    output logic                       o_found,
    output logic [tbws_pkg::IDX_W-1:0] o_found_index,
    output logic [tbws_pkg::IDX_W-1:0] o_lowest_member,
    output logic [tbws_pkg::IDX_W-1:0] o_highest_member,
    output logic [tbws_pkg::CNT_W-1:0] o_member_count,
    output logic [tbws_pkg::SUM_W-1:0] o_member_sum,
    output logic                       o_set_empty
);

    tbws_pkg::t_cmd cmd;
    tbws_pkg::t_sts sts;

    // Sequence each item: load, update or start a walk, walk, hand off result
    tbws_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    // Store, trackers, word walk and output register
    tbws_dp #(
        .SET_BITS (SET_BITS),
        .WORD_BITS(WORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req_type),
        .i_index         (i_index),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_bit_value     (o_bit_value),
        .o_found         (o_found),
        .o_found_index   (o_found_index),
        .o_lowest_member (o_lowest_member),
        .o_highest_member(o_highest_member),
        .o_member_count  (o_member_count),
        .o_member_sum    (o_member_sum),
        .o_set_empty     (o_set_empty)
    );

    // Hold one item at a time: no acceptance right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while an item is in work");

    // Empty flag agrees with the count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_set_empty == (o_member_count == '0)))
        else $error("empty flag disagrees with member count");

    // Lowest never above highest while the set holds members
    a_low_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_set_empty) |-> (o_lowest_member <= o_highest_member))
        else $error("lowest member above highest member");

    // A miss reports index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_found_index == '0))
        else $error("nonzero found index without a hit");

endmodule
